[design/wfps_pkg.sv]
// Shared constants, types and tables for the wall-follow steering block.
package wfps_pkg;

  localparam int DefMaxSamples = 2048;
  localparam int DefCordicSteps = 16;

  localparam logic [15:0] DefaultRange = 16'd10000;
  localparam logic [16:0] Cos45Q16 = 17'd46341;
  localparam logic [15:0] InvGainQ16 = 16'd39797;
  localparam logic signed [19:0] NegHalfPiQ16 = -20'sd102944;

  localparam logic [2:0] RegSideIdx = 3'd0;
  localparam logic [2:0] RegDiagIdx = 3'd1;
  localparam logic [2:0] RegGainP = 3'd2;
  localparam logic [2:0] RegGainI = 3'd3;
  localparam logic [2:0] RegGainD = 3'd4;
  localparam logic [2:0] RegDesired = 3'd5;

  // One end-of-scan job handed from the sample front end to the math engine.
  typedef struct packed {
    logic [15:0] side_range;
    logic [15:0] diag_range;
  } scan_job_t;

  function automatic logic signed [19:0] atan_q16(input logic [4:0] i);
    logic signed [19:0] v;
    case (i)
      5'd0: v = 20'sd51472;
      5'd1: v = 20'sd30385;
      5'd2: v = 20'sd16055;
      5'd3: v = 20'sd8150;
      5'd4: v = 20'sd4091;
      5'd5: v = 20'sd2047;
      5'd6: v = 20'sd1024;
      5'd7: v = 20'sd512;
      5'd8: v = 20'sd256;
      5'd9: v = 20'sd128;
      5'd10: v = 20'sd64;
      5'd11: v = 20'sd32;
      5'd12: v = 20'sd16;
      5'd13: v = 20'sd8;
      5'd14: v = 20'sd4;
      5'd15: v = 20'sd2;
      5'd16: v = 20'sd1;
      default: v = 20'sd0;
    endcase
    return v;
  endfunction

endpackage

[design/wall_follow_pid_steering.sv]
// Top level of the wall-follow PID steering block.
// Usage: range samples enter on the in_ channel (valid/ready), one beat per
// sample; the beat with in_last_sample set closes the scan. Each scan yields
// exactly one result beat on the out_ channel: steering (Q15.16 rad), speed
// and wall error. Ordinary samples are taken every cycle; they only advance
// the sample counter and capture the side and diagonal beams.
// The closing beat is handed to a two-deep job queue. The math engine takes
// one job at a time: a CORDIC angle pass (skipped when the diagonal range is
// zero) and a CORDIC rotation pass of one step a cycle, the P, I and D
// multiplies, scale, and a reciprocal divide (low half, high half, finish).
// in_ready drops only on a closing beat while the queue is full, so a stalled
// receiver holds results in the engine and backs up into the queue.
// The user must write configuration on the cfg_ channel only while the block
// is idle; the block itself does not enforce this (cfg_ready is tied high).
// Reset (synchronous, rst_n low) clears the counter, ranges to 10000 mm,
// the integral and previous error, and restores register defaults.
module wall_follow_pid_steering import wfps_pkg::*; #(
  parameter int MAX_SAMPLES = DefMaxSamples,
  parameter int CORDIC_STEPS = DefCordicSteps
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_range_mm,
  input  logic               in_range_valid,
  input  logic               in_last_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_steering,
  output logic [10:0]        out_speed_mm_s,
  output logic signed [16:0] out_wall_error,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  logic [10:0] side_idx_r, diag_idx_r;
  logic [15:0] gp_r, gi_r, gd_r, des_r;
  logic fq_valid, fq_ready, qb_valid, qb_ready;
  scan_job_t fq_job, qb_job;

  assign cfg_ready = 1'b1;

  // Hold register values; decode the index and drop unknown ones.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_idx_r <= 11'd540;
      diag_idx_r <= 11'd405;
      gp_r <= 16'd256;
      gi_r <= 16'd0;
      gd_r <= 16'd26;
      des_r <= 16'd1000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegSideIdx: side_idx_r <= cfg_data[10:0];
        RegDiagIdx: diag_idx_r <= cfg_data[10:0];
        RegGainP: gp_r <= cfg_data;
        RegGainI: gi_r <= cfg_data;
        RegGainD: gd_r <= cfg_data;
        RegDesired: des_r <= cfg_data;
        default: ;
      endcase
    end
  end

  wfps_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_range_mm, .in_range_valid,
    .in_last_sample, .side_idx(side_idx_r), .diag_idx(diag_idx_r),
    .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
  );

  wfps_queue u_queue (
    .clk, .rst_n, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_job),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_job)
  );

  wfps_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst_n, .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
    .gain_p(gp_r), .gain_i(gi_r), .gain_d(gd_r), .desired(des_r),
    .out_valid, .out_ready, .out_steering, .out_speed_mm_s, .out_wall_error
  );
endmodule

[design/wfps_front.sv]
// Sample counter and side/diagonal beam capture; emits one job per scan.
module wfps_front import wfps_pkg::*; #(
  parameter int MAX_SAMPLES = DefMaxSamples
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       in_range_mm,
  input  logic              in_range_valid,
  input  logic              in_last_sample,
  input  logic [10:0]       side_idx,
  input  logic [10:0]       diag_idx,
  output logic              job_valid,
  input  logic              job_ready,
  output scan_job_t         job
);
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic [15:0] side_r, side_nxt, diag_r, diag_nxt;
  logic [15:0] sample;
  logic        acc;

  // Stall only the last sample of a scan while the queue is full.
  assign in_ready = !in_last_sample || job_ready;
  assign acc = in_valid && in_ready;
  assign sample = in_range_valid ? in_range_mm : DefaultRange;

  always_comb begin
    count_nxt = count_r;
    side_nxt = side_r;
    diag_nxt = diag_r;
    if (count_r < CW'(MAX_SAMPLES)) begin
      if ({{(CW > 11 ? CW - 11 : 0){1'b0}}, side_idx} == (CW > 11 ? CW : 11)'(count_r))
        side_nxt = sample;
      if ({{(CW > 11 ? CW - 11 : 0){1'b0}}, diag_idx} == (CW > 11 ? CW : 11)'(count_r))
        diag_nxt = sample;
      count_nxt = count_r + CW'(1);
    end
  end

  assign job_valid = acc && in_last_sample;
  assign job.side_range = side_nxt;
  assign job.diag_range = diag_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      side_r <= DefaultRange;
      diag_r <= DefaultRange;
    end else if (acc) begin
      if (in_last_sample) begin
        count_r <= '0;
        side_r <= DefaultRange;
        diag_r <= DefaultRange;
      end else begin
        count_r <= count_nxt;
        side_r <= side_nxt;
        diag_r <= diag_nxt;
      end
    end
  end
endmodule

[design/wfps_queue.sv]
// Two-entry job queue between the front end and the math engine.
module wfps_queue import wfps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  scan_job_t wr_data,
  output logic      rd_valid,
  input  logic      rd_ready,
  output scan_job_t rd_data
);
  scan_job_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

[design/wfps_back.sv]
// Math engine: CORDIC angle, projection, PID and speed tier, one job at a time.
module wfps_back import wfps_pkg::*; #(
  parameter int CORDIC_STEPS = DefCordicSteps
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  output logic                job_ready,
  input  scan_job_t           job,
  input  logic [15:0]         gain_p,
  input  logic [15:0]         gain_i,
  input  logic [15:0]         gain_d,
  input  logic [15:0]         desired,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_steering,
  output logic [10:0]         out_speed_mm_s,
  output logic signed [16:0]  out_wall_error
);
  localparam int NS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int SW = $clog2(NS);

  // ceil(2^45 / 125): exact quotient for any dividend below 2^38.
  localparam logic [38:0] RecipQ45 = 39'd281474976711;
  // 125 * 2^31: at or above this the quotient no longer fits 31 bits.
  localparam logic [59:0] OvfLimit = 60'd268435456000;

  localparam logic [3:0] S_IDLE = 4'd0, S_VEC = 4'd1, S_ROTI = 4'd2, S_ROT = 4'd3,
    S_MUL = 4'd4, S_ERR = 4'd5, S_P1 = 4'd6, S_P2 = 4'd7, S_P3 = 4'd8,
    S_SCL = 4'd9, S_DIV = 4'd10, S_OUT = 4'd11, S_DV2 = 4'd12, S_FIN = 4'd13;

  logic [3:0] st_r;
  logic [SW-1:0] i_r;
  logic signed [35:0] x_r, y_r;
  logic signed [19:0] z_r;
  logic [15:0] b_r;
  logic signed [52:0] acc_r;
  logic signed [16:0] err_r, prev_r;
  logic signed [39:0] sum_r;
  logic signed [17:0] drv_r;
  logic signed [59:0] pid_r;
  logic [37:0] mag_r;
  logic ovf_r;
  logic [76:0] prod_r;
  logic neg_r;
  logic signed [31:0] steer_r;
  logic [10:0] speed_r;

  logic signed [35:0] xs, ys;
  logic signed [19:0] at;
  logic step_last;
  logic signed [53:0] d_full;
  logic signed [40:0] sum_ext;
  logic signed [39:0] sum_sat;
  logic [16:0] emag;
  logic [59:0] mag_full;
  logic [57:0] pp;

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign at = atan_q16(5'(i_r));
  assign step_last = i_r == SW'(NS - 1);

  assign job_ready = st_r == S_IDLE;
  assign out_valid = st_r == S_OUT;
  assign out_steering = steer_r;
  assign out_speed_mm_s = speed_r;
  assign out_wall_error = err_r;

  assign d_full = 54'(acc_r >>> 32) - $signed({38'd0, desired});
  assign sum_ext = 41'(sum_r) + 41'(err_r);
  assign sum_sat = (sum_ext > 41'sd549755813887) ? 40'sd549755813887 :
                   (sum_ext < -41'sd549755813888) ? -40'sd549755813888 : sum_ext[39:0];
  assign emag = err_r[16] ? 17'(-err_r) : err_r;
  assign mag_full = ((pid_r < 0) ? 60'(-pid_r) : 60'(pid_r)) * 60'd32 + 60'd62;
  // One 19 x 39 partial product: low half of the dividend first, then the high half.
  assign pp = ((st_r == S_DIV) ? mag_r[18:0] : mag_r[37:19]) * RecipQ45;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      prev_r <= '0;
      sum_r <= '0;
      i_r <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: if (job_valid) begin
          b_r <= job.side_range;
          i_r <= '0;
          x_r <= $signed(36'(job.diag_range) * 36'(Cos45Q16));
          y_r <= $signed(36'(job.diag_range) * 36'(Cos45Q16)) - $signed(36'(job.side_range) <<< 16);
          z_r <= (job.diag_range == 16'd0) ? NegHalfPiQ16 : '0;
          st_r <= (job.diag_range == 16'd0) ? S_ROTI : S_VEC;
        end
        S_VEC: begin
          if (y_r < 0) begin
            x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - at;
          end else begin
            x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + at;
          end
          i_r <= i_r + SW'(1);
          if (step_last) st_r <= S_ROTI;
        end
        S_ROTI: begin
          x_r <= $signed(36'(b_r) <<< 16);
          y_r <= 36'sd65536000;
          z_r <= -z_r;
          i_r <= '0;
          st_r <= S_ROT;
        end
        S_ROT: begin
          if (z_r >= 0) begin
            x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - at;
          end else begin
            x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + at;
          end
          i_r <= i_r + SW'(1);
          if (step_last) st_r <= S_MUL;
        end
        S_MUL: begin
          acc_r <= 53'(x_r) * $signed({37'd0, InvGainQ16}) + 53'sd2147483648;
          st_r <= S_ERR;
        end
        S_ERR: begin
          err_r <= (d_full > 54'sd65535) ? 17'sd65535 :
                   (d_full < -54'sd65536) ? -17'sd65536 : d_full[16:0];
          st_r <= S_P1;
        end
        S_P1: begin
          sum_r <= sum_sat;
          drv_r <= 18'(err_r) - 18'(prev_r);
          prev_r <= err_r;
          pid_r <= 60'(err_r) * $signed({44'd0, gain_p});
          st_r <= S_P2;
        end
        S_P2: begin
          pid_r <= pid_r + 60'(sum_r) * $signed({44'd0, gain_i});
          st_r <= S_P3;
        end
        S_P3: begin
          pid_r <= pid_r + 60'(drv_r) * $signed({44'd0, gain_d});
          speed_r <= (emag < 17'd100) ? 11'd1500 : (emag < 17'd300) ? 11'd1000 : 11'd500;
          st_r <= S_SCL;
        end
        S_SCL: begin
          neg_r <= pid_r < 0;
          ovf_r <= mag_full >= OvfLimit;
          mag_r <= mag_full[37:0];
          i_r <= '0;
          st_r <= S_DIV;
        end
        S_DIV: begin
          // Divide by 125 with a reciprocal multiply, one half of the dividend a cycle.
          prod_r <= {19'd0, pp};
          st_r <= S_DV2;
        end
        S_DV2: begin
          prod_r <= prod_r + {pp, 19'd0};
          st_r <= S_FIN;
        end
        S_FIN: begin
          if (ovf_r) steer_r <= neg_r ? 32'sh80000000 : 32'sh7fffffff;
          else steer_r <= neg_r ? -$signed(prod_r[76:45]) : $signed(prod_r[76:45]);
          st_r <= S_OUT;
        end
        S_OUT: if (out_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
